// ===== design/assert_macros.svh =====
// Assertion macros for the map center block.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define GMC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// implication check
`define GMC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

// ===== design/gmc_pkg.sv =====
// Shared types, constants and the arctangent table of the map center block.
// No dependencies.
package gmc_pkg;

  localparam int MAX_POINTS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 18;

  localparam int LAT_W = 28;
  localparam int LON_W = 29;
  localparam int ANG_W = 32;
  localparam int ROT_W = 20;

  localparam logic signed [ANG_W-1:0] DEG90  = 32'sd90000000;
  localparam logic signed [ANG_W-1:0] DEG180 = 32'sd180000000;
  localparam logic signed [ANG_W-1:0] DEG360 = 32'sd360000000;
  localparam logic signed [ANG_W-1:0] DEG540 = 32'sd540000000;
  localparam logic signed [17:0]      GAIN_Q16 = 18'sd39797;

  typedef struct packed {
    logic                    point;
    logic                    self_mark;
    logic                    last;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
  } cmd_t;

  typedef enum logic [4:0] {
    B_IDLE, B_CMD, B_ROT, B_MUL, B_ACC, B_FIN, B_V1, B_HYP, B_V2S, B_V2,
    B_RRD, B_RLD, B_PINIT, B_PRD, B_PDIF, B_PR1, B_PR2, B_PUPD, B_CEN,
    B_WRAP, B_OUT
  } back_state_e;

  // atan(2^-i) in microdegrees
  function automatic logic signed [ANG_W-1:0] atan_ud(input logic [4:0] idx);
    logic signed [ANG_W-1:0] a;
    unique case (idx)
      5'd0:  a = 32'sd45000000;
      5'd1:  a = 32'sd26565051;
      5'd2:  a = 32'sd14036243;
      5'd3:  a = 32'sd7125016;
      5'd4:  a = 32'sd3576334;
      5'd5:  a = 32'sd1789911;
      5'd6:  a = 32'sd895174;
      5'd7:  a = 32'sd447614;
      5'd8:  a = 32'sd223811;
      5'd9:  a = 32'sd111906;
      5'd10: a = 32'sd55953;
      5'd11: a = 32'sd27976;
      5'd12: a = 32'sd13988;
      5'd13: a = 32'sd6994;
      5'd14: a = 32'sd3497;
      5'd15: a = 32'sd1749;
      5'd16: a = 32'sd874;
      5'd17: a = 32'sd437;
      5'd18: a = 32'sd219;
      5'd19: a = 32'sd109;
      5'd20: a = 32'sd55;
      5'd21: a = 32'sd27;
      5'd22: a = 32'sd14;
      5'd23: a = 32'sd7;
      5'd24: a = 32'sd3;
      5'd25: a = 32'sd2;
      5'd26: a = 32'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== design/geo_map_center_bounds.sv =====
// Map center of a point set: front end, two-entry queue, CORDIC back end.
// Each position beat runs the lat/lon rotation CORDICs in the back end.
// The closing beat adds a vectoring CORDIC pass (when no self point is marked) and a bounds pass.
// Input beats are taken while the queue has room; result sits in an output register.
// Reset clears control state, counts and sums; the point store needs no clearing.
module geo_map_center_bounds import gmc_pkg::*; #(
  parameter int MAX_POINTS   = MAX_POINTS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    has_point_i,
  input  logic signed [LAT_W-1:0] lat_micro_i,
  input  logic signed [LON_W-1:0] lon_micro_i,
  input  logic                    self_point_i,
  input  logic                    last_point_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [LAT_W-1:0] center_lat_micro_o,
  output logic signed [LON_W-1:0] center_lon_micro_o
);

`include "assert_macros.svh"

  logic push, pop, q_full, q_empty;
  cmd_t cmd_in, cmd_out;

  gmc_front u_front (
    .in_valid_i, .in_ready_o, .has_point_i, .lat_micro_i, .lon_micro_i,
    .self_point_i, .last_point_i, .q_full_i(q_full), .push_o(push), .cmd_o(cmd_in)
  );

  gmc_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(cmd_in), .pop_i(pop),
    .data_o(cmd_out), .full_o(q_full), .empty_o(q_empty)
  );

  gmc_back #(.MAX_POINTS(MAX_POINTS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk_i, .rst_ni, .q_data_i(cmd_out), .q_empty_i(q_empty), .q_pop_o(pop),
    .out_ready_i, .out_valid_o, .out_lat_o(center_lat_micro_o),
    .out_lon_o(center_lon_micro_o)
  );

  `GMC_ASSERT_IMP(a_push_room, push, !q_full)
  `GMC_ASSERT_IMP(a_pop_data, pop, !q_empty)
  `GMC_ASSERT_IMP(a_lon_range, out_valid_o,
                  (center_lon_micro_o >= -DEG180) && (center_lon_micro_o < DEG180))

endmodule

// ===== design/gmc_front.sv =====
// Front end: accepts input beats, clamps and wraps positions, classifies them.
// Depends on gmc_pkg.
module gmc_front import gmc_pkg::*; (
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    has_point_i,
  input  logic signed [LAT_W-1:0] lat_micro_i,
  input  logic signed [LON_W-1:0] lon_micro_i,
  input  logic                    self_point_i,
  input  logic                    last_point_i,
  input  logic                    q_full_i,
  output logic                    push_o,
  output cmd_t                    cmd_o
);

  logic signed [ANG_W-1:0] lat_w, lon_w, lon_adj;

  always_comb begin
    lat_w = ANG_W'(lat_micro_i);
    lon_w = ANG_W'(lon_micro_i);
    if (lat_w > DEG90) begin
      lat_w = DEG90;
    end else if (lat_w < -DEG90) begin
      lat_w = -DEG90;
    end
    if (lon_w > DEG180) begin
      lon_adj = lon_w - DEG360;
    end else if (lon_w < -DEG180) begin
      lon_adj = lon_w + DEG360;
    end else begin
      lon_adj = lon_w;
    end
  end

  assign in_ready_o = !q_full_i;
  // beats with neither a position nor an end mark are taken and dropped
  assign push_o = in_valid_i && !q_full_i && (has_point_i || last_point_i);

  always_comb begin
    cmd_o.point     = has_point_i;
    cmd_o.self_mark = has_point_i && self_point_i;
    cmd_o.last      = last_point_i;
    cmd_o.lat       = lat_w[LAT_W-1:0];
    cmd_o.lon       = lon_adj[LON_W-1:0];
  end

endmodule

// ===== design/gmc_queue.sv =====
// Two-entry command queue between front and back end.
// Depends on gmc_pkg.
module gmc_queue import gmc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== design/gmc_cordic.sv =====
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// Depends on gmc_pkg for the arctangent table.
module gmc_cordic import gmc_pkg::*; #(
  parameter int W     = ROT_W,
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    vec_i,
  input  logic signed [W-1:0]     x_i,
  input  logic signed [W-1:0]     y_i,
  input  logic signed [ANG_W-1:0] z_i,
  output logic                    done_o,
  output logic signed [W-1:0]     x_o,
  output logic signed [W-1:0]     y_o,
  output logic signed [ANG_W-1:0] z_o
);

  localparam int CW = $clog2(STEPS + 1);

  logic signed [W-1:0]     x_q, y_q, dx, dy;
  logic signed [ANG_W-1:0] z_q, a;
  logic [CW-1:0]           cnt_q;
  logic                    busy_q, done_q, vec_q, pos;

  always_comb begin
    dx  = y_q >>> cnt_q;
    dy  = x_q >>> cnt_q;
    a   = atan_ud(5'(cnt_q));
    pos = vec_q ? (y_q <= 0) : (z_q >= 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      y_q   <= y_i;
      z_q   <= z_i;
      vec_q <= vec_i;
    end else if (busy_q) begin
      if (pos) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - a;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + a;
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

// ===== design/gmc_back.sv =====
// Back end: point store, vector sums, reference search, bounds pass, output.
// Depends on gmc_pkg and gmc_cordic.
module gmc_back import gmc_pkg::*; #(
  parameter int MAX_POINTS   = MAX_POINTS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    q_data_i,
  input  logic                    q_empty_i,
  output logic                    q_pop_o,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic signed [LAT_W-1:0] out_lat_o,
  output logic signed [LON_W-1:0] out_lon_o
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = 18 + IDX_W;
  localparam int VW    = SUM_W + 10;

  back_state_e state_q, state_d;

  cmd_t                    cmd_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    self_seen_q;
  logic [IDX_W-1:0]        self_idx_q, i_q, rd_addr;
  logic signed [SUM_W-1:0] sum_q [3];
  logic signed [SUM_W-1:0] p0_q, p1_q, p2_q;
  logic                    neg_q;

  logic signed [LAT_W-1:0] lat_mem [MAX_POINTS];
  logic signed [LON_W-1:0] lon_mem [MAX_POINTS];
  logic signed [LAT_W-1:0] rd_lat_q;
  logic signed [LON_W-1:0] rd_lon_q;

  logic signed [ANG_W-1:0] rlat_q, rlon_q, north_q, south_q, east_q, west_q;
  logic signed [ANG_W-1:0] de_q, dw_q, plat_q, diff, t2;
  logic signed [VW-1:0]    mag_q, hyp_q;
  logic signed [LAT_W-1:0] clat_q;
  logic signed [32:0]      r_q, ns_sum, we_sum, lon_fin;
  logic signed [VW+17:0]   hyp_prod;

  logic                    pop, mem_we, rot_start, vec_start, out_load;
  logic                    can_store, last_idx;

  // rotation units
  logic signed [ANG_W-1:0] lon_fold, lat_z, rz0, rz1;
  logic                    fold_neg, rot_done, rot1_done;
  logic signed [ROT_W-1:0] cl, sl, co, sn, co_n, sn_n;
  logic signed [2*ROT_W-1:0] prod0, prod1;

  // vectoring unit
  logic signed [VW-1:0]    vx_raw, vy_raw, vx_in, vy_in, vx_o, vy_o;
  logic signed [ANG_W-1:0] vbase, vz_o;
  logic                    vzero, vec_done;

  logic                    out_valid_q;
  logic signed [LAT_W-1:0] out_lat_q;
  logic signed [LON_W-1:0] out_lon_q;

  assign can_store = cnt_q < CNT_W'(MAX_POINTS);
  assign last_idx  = (CNT_W'(i_q) == cnt_q - 1'b1);

  always_comb begin
    lat_z    = ANG_W'(cmd_q.lat);
    lon_fold = ANG_W'(cmd_q.lon);
    fold_neg = 1'b0;
    if (lon_fold > DEG90) begin
      lon_fold = lon_fold - DEG180;
      fold_neg = 1'b1;
    end else if (lon_fold < -DEG90) begin
      lon_fold = lon_fold + DEG180;
      fold_neg = 1'b1;
    end
  end

  gmc_cordic #(.W(ROT_W), .STEPS(CORDIC_STEPS)) u_rot_lat (
    .clk_i, .rst_ni, .start_i(rot_start), .vec_i(1'b0),
    .x_i(ROT_W'(GAIN_Q16)), .y_i('0), .z_i(lat_z),
    .done_o(rot_done), .x_o(cl), .y_o(sl), .z_o(rz0)
  );

  gmc_cordic #(.W(ROT_W), .STEPS(CORDIC_STEPS)) u_rot_lon (
    .clk_i, .rst_ni, .start_i(rot_start), .vec_i(1'b0),
    .x_i(ROT_W'(GAIN_Q16)), .y_i('0), .z_i(lon_fold),
    .done_o(rot1_done), .x_o(co), .y_o(sn), .z_o(rz1)
  );

  always_comb begin
    co_n  = neg_q ? -co : co;
    sn_n  = neg_q ? -sn : sn;
    prod0 = cl * co_n;
    prod1 = cl * sn_n;
  end

  always_comb begin
    if (state_q == B_FIN) begin
      vx_raw = VW'(sum_q[0]) <<< 8;
      vy_raw = VW'(sum_q[1]) <<< 8;
    end else begin
      vx_raw = hyp_q;
      vy_raw = VW'(sum_q[2]) <<< 8;
    end
    vzero = (vx_raw == '0) && (vy_raw == '0);
    if (vx_raw < 0) begin
      vx_in = -vx_raw;
      vy_in = -vy_raw;
      vbase = (vy_raw >= 0) ? DEG180 : -DEG180;
    end else begin
      vx_in = vx_raw;
      vy_in = vy_raw;
      vbase = '0;
    end
  end

  gmc_cordic #(.W(VW), .STEPS(CORDIC_STEPS)) u_vec (
    .clk_i, .rst_ni, .start_i(vec_start), .vec_i(1'b1),
    .x_i(vx_in), .y_i(vy_in), .z_i(vbase),
    .done_o(vec_done), .x_o(vx_o), .y_o(vy_o), .z_o(vz_o)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:  if (!q_empty_i) state_d = B_CMD;
      B_CMD: begin
        if (cmd_q.point && can_store) state_d = B_ROT;
        else if (cmd_q.last)          state_d = B_FIN;
        else                          state_d = B_IDLE;
      end
      B_ROT:   if (rot_done) state_d = B_MUL;
      B_MUL:   state_d = B_ACC;
      B_ACC:   state_d = cmd_q.last ? B_FIN : B_IDLE;
      B_FIN: begin
        if (cnt_q == '0)      state_d = B_OUT;
        else if (self_seen_q) state_d = B_RRD;
        else if (vzero)       state_d = B_HYP;
        else                  state_d = B_V1;
      end
      B_V1:    if (vec_done) state_d = B_HYP;
      B_HYP:   state_d = B_V2S;
      B_V2S:   state_d = vzero ? B_PINIT : B_V2;
      B_V2:    if (vec_done) state_d = B_PINIT;
      B_RRD:   state_d = B_RLD;
      B_RLD:   state_d = B_PINIT;
      B_PINIT: state_d = B_PRD;
      B_PRD:   state_d = B_PDIF;
      B_PDIF:  state_d = B_PR1;
      B_PR1:   state_d = B_PR2;
      B_PR2:   state_d = B_PUPD;
      B_PUPD:  state_d = last_idx ? B_CEN : B_PRD;
      B_CEN:   state_d = B_WRAP;
      B_WRAP:  if (r_q >= 0 && r_q < 33'(DEG360)) state_d = B_OUT;
      B_OUT:   if (!out_valid_q || out_ready_i) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop       = 1'b0;
    mem_we    = 1'b0;
    rot_start = 1'b0;
    vec_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      B_IDLE: pop = !q_empty_i;
      B_CMD: begin
        mem_we    = cmd_q.point && can_store;
        rot_start = cmd_q.point && can_store;
      end
      B_FIN:   vec_start = (cnt_q != '0) && !self_seen_q && !vzero;
      B_V2S:   vec_start = !vzero;
      B_OUT:   out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign q_pop_o = pop;
  assign rd_addr = (state_q == B_RRD) ? self_idx_q : i_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      self_seen_q <= 1'b0;
      self_idx_q  <= '0;
      sum_q[0]    <= '0;
      sum_q[1]    <= '0;
      sum_q[2]    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mem_we) begin
        if (cmd_q.self_mark && !self_seen_q) begin
          self_seen_q <= 1'b1;
          self_idx_q  <= cnt_q[IDX_W-1:0];
        end
      end
      if (state_q == B_ACC) begin
        sum_q[0] <= sum_q[0] + p0_q;
        sum_q[1] <= sum_q[1] + p1_q;
        sum_q[2] <= sum_q[2] + p2_q;
        cnt_q    <= cnt_q + 1'b1;
      end
      if (out_load) begin
        cnt_q       <= '0;
        self_seen_q <= 1'b0;
        self_idx_q  <= '0;
        sum_q[0]    <= '0;
        sum_q[1]    <= '0;
        sum_q[2]    <= '0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lat_mem[cnt_q[IDX_W-1:0]] <= cmd_q.lat;
      lon_mem[cnt_q[IDX_W-1:0]] <= cmd_q.lon;
    end
    rd_lat_q <= lat_mem[rd_addr];
    rd_lon_q <= lon_mem[rd_addr];
  end

  always_comb begin
    diff     = ANG_W'(rd_lon_q) - rlon_q;
    t2       = diff - DEG360;
    ns_sum   = 33'(north_q) + 33'(south_q);
    we_sum   = 33'(west_q) + 33'(east_q);
    lon_fin  = r_q - 33'(DEG180);
    hyp_prod = (VW+18)'(mag_q) * (VW+18)'(GAIN_Q16);
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: if (!q_empty_i) cmd_q <= q_data_i;
      B_CMD:  neg_q <= fold_neg;
      B_MUL: begin
        p0_q <= SUM_W'(prod0 >>> 16);
        p1_q <= SUM_W'(prod1 >>> 16);
        p2_q <= SUM_W'(sl);
      end
      B_FIN: begin
        if (cnt_q == '0) begin
          clat_q <= '0;
          r_q    <= 33'(DEG180);
        end else if (vzero) begin
          rlon_q <= '0;
          mag_q  <= '0;
        end
      end
      B_V1: if (vec_done) begin
        rlon_q <= vz_o;
        mag_q  <= vx_o;
      end
      B_HYP: hyp_q <= VW'(hyp_prod >>> 16);
      B_V2S: if (vzero) rlat_q <= '0;
      B_V2:  if (vec_done) rlat_q <= vz_o;
      B_RLD: begin
        rlat_q <= ANG_W'(rd_lat_q);
        rlon_q <= ANG_W'(rd_lon_q);
      end
      B_PINIT: begin
        north_q <= rlat_q;
        south_q <= rlat_q;
        east_q  <= rlon_q;
        west_q  <= rlon_q;
        i_q     <= '0;
      end
      B_PDIF: begin
        de_q   <= diff + DEG360;
        dw_q   <= (t2 < 0) ? -t2 : t2;
        plat_q <= ANG_W'(rd_lat_q);
      end
      B_PR1, B_PR2: begin
        if (de_q >= DEG360) de_q <= de_q - DEG360;
        if (dw_q >= DEG360) dw_q <= dw_q - DEG360;
      end
      B_PUPD: begin
        if (plat_q > north_q) north_q <= plat_q;
        if (plat_q < south_q) south_q <= plat_q;
        if (de_q < dw_q) begin
          if (rlon_q + de_q > east_q) east_q <= rlon_q + de_q;
        end else begin
          if (rlon_q - dw_q < west_q) west_q <= rlon_q - dw_q;
        end
        i_q <= i_q + 1'b1;
      end
      B_CEN: begin
        clat_q <= LAT_W'(ns_sum >>> 1);
        r_q    <= (we_sum >>> 1) + 33'(DEG540);
      end
      B_WRAP: begin
        if (r_q < 0) r_q <= r_q + 33'(DEG360);
        else if (r_q >= 33'(DEG360)) r_q <= r_q - 33'(DEG360);
      end
      default: ;
    endcase
    if (out_load) begin
      out_lat_q <= clat_q;
      out_lon_q <= lon_fin[LON_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_lat_o   = out_lat_q;
  assign out_lon_o   = out_lon_q;

endmodule

// ===== test/center_checker.sv =====
// Checker for geo_map_center_bounds: watches both channels, predicts map centers
// from accepted input beats and compares them with the result beats. Uses gmc_pkg.
`timescale 1ns / 100ps

module center_checker import gmc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    has_point_i,
  input  logic signed [LAT_W-1:0] lat_micro_i,
  input  logic signed [LON_W-1:0] lon_micro_i,
  input  logic                    self_point_i,
  input  logic                    last_point_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic signed [LAT_W-1:0] center_lat_micro_i,
  input  logic signed [LON_W-1:0] center_lon_micro_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  localparam int NPTS  = MAX_POINTS_DEF;
  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam longint D90 = 90000000, D180 = 180000000, D360 = 360000000;
  localparam longint D540 = 540000000, GAIN = 39797;

  typedef struct {
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
  } center_t;

  longint atan_lut [32] = '{45000000, 26565051, 14036243, 7125016, 3576334, 1789911,
    895174, 447614, 223811, 111906, 55953, 27976, 13988, 6994, 3497, 1749,
    874, 437, 219, 109, 55, 27, 14, 7, 3, 2, 1, 0, 0, 0, 0, 0};

  longint  lat_mem [NPTS];
  longint  lon_mem [NPTS];
  int      n_pts;
  bit      have_self;
  int      self_at;
  longint  vsum [3];
  center_t centers_q [$];

  function automatic void sin_cos(input longint ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = GAIN; y = 0; z = ang;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_lut[i];
      end else begin
        x += dx; y -= dy; z += atan_lut[i];
      end
    end
    c = x; s = y;
  endfunction

  function automatic longint arctan2(input longint xi, input longint yi, output longint mag);
    longint x, y, z, base, dx, dy;
    x = xi; y = yi; z = 0; base = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      base = (y >= 0) ? D180 : -D180;
      x = -x; y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_lut[i];
      end else begin
        x -= dx; y += dy; z -= atan_lut[i];
      end
    end
    mag = x;
    return base + z;
  endfunction

  task automatic store_point(input longint lat_in, input longint lon_in, input bit self_m);
    longint lat, lon, cl, sl, co, sn;
    bit flip;
    lat = lat_in; lon = lon_in; flip = 0;
    if (lat > D90) lat = D90;
    if (lat < -D90) lat = -D90;
    if (lon > D180) lon -= D360;
    else if (lon < -D180) lon += D360;
    lat_mem[n_pts] = lat;
    lon_mem[n_pts] = lon;
    if (self_m && !have_self) begin
      have_self = 1;
      self_at = n_pts;
    end
    sin_cos(lat, cl, sl);
    if (lon > D90) begin
      lon -= D180; flip = 1;
    end else if (lon < -D90) begin
      lon += D180; flip = 1;
    end
    sin_cos(lon, co, sn);
    if (flip) begin
      co = -co; sn = -sn;
    end
    vsum[0] += (cl * co) >>> 16;
    vsum[1] += (cl * sn) >>> 16;
    vsum[2] += sl;
    n_pts++;
  endtask

  function automatic center_t predict_center();
    center_t r;
    longint rlat, rlon, mag, hyp, north, south, east, west, d, de, dw, clat, clon;
    if (n_pts == 0) begin
      r.lat = '0; r.lon = '0;
      return r;
    end
    if (have_self) begin
      rlat = lat_mem[self_at];
      rlon = lon_mem[self_at];
    end else begin
      rlon = arctan2(vsum[0] * 256, vsum[1] * 256, mag);
      hyp = (mag * GAIN) >>> 16;
      rlat = arctan2(hyp, vsum[2] * 256, mag);
    end
    north = rlat; south = rlat; east = rlon; west = rlon;
    for (int i = 0; i < n_pts; i++) begin
      d = lon_mem[i] - rlon;
      de = (d + D360) % D360;
      dw = (d - D360) % D360;
      if (dw < 0) dw = -dw;
      if (lat_mem[i] > north) north = lat_mem[i];
      if (lat_mem[i] < south) south = lat_mem[i];
      if (de < dw) begin
        if (rlon + de > east) east = rlon + de;
      end else if (rlon - dw < west) begin
        west = rlon - dw;
      end
    end
    clat = (north + south) >>> 1;
    clon = (west + east) >>> 1;
    clon = (clon + D540) % D360;
    if (clon < 0) clon += D360;
    clon -= D180;
    r.lat = clat[LAT_W-1:0];
    r.lon = clon[LON_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    center_t e;
    if (!rst_ni) begin
      n_pts = 0; have_self = 0; self_at = 0;
      vsum[0] = 0; vsum[1] = 0; vsum[2] = 0;
      centers_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (has_point_i && n_pts < NPTS)
          store_point(lat_micro_i, lon_micro_i, self_point_i);
        if (last_point_i) begin
          centers_q.push_back(predict_center());
          n_pts = 0; have_self = 0; self_at = 0;
          vsum[0] = 0; vsum[1] = 0; vsum[2] = 0;
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (centers_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result beat: lat %0d lon %0d",
                     center_lat_micro_i, center_lon_micro_i);
        end else begin
          e = centers_q.pop_front();
          if (e.lat !== center_lat_micro_i || e.lon !== center_lon_micro_i) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("center mismatch: expected lat %0d lon %0d, got lat %0d lon %0d",
                       e.lat, e.lon, center_lat_micro_i, center_lon_micro_i);
          end
        end
      end
      pending_o = centers_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
// Testbench top for geo_map_center_bounds: clock, reset, point-set stimulus and verdict.
// Depends on gmc_pkg, the block itself and center_checker.
`timescale 1ns / 100ps

module tb;
  import gmc_pkg::*;

  logic                    clk_i, rst_ni;
  logic                    in_valid_i, in_ready_o;
  logic                    has_point_i, self_point_i, last_point_i;
  logic signed [LAT_W-1:0] lat_micro_i;
  logic signed [LON_W-1:0] lon_micro_i;
  logic                    out_valid_o, out_ready_i;
  logic signed [LAT_W-1:0] center_lat_micro_o;
  logic signed [LON_W-1:0] center_lon_micro_o;
  int                      fail_count, pending;
  bit                      calm;
  int                      n_sent;

  geo_map_center_bounds uut (.*);

  center_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .has_point_i,
    .lat_micro_i, .lon_micro_i, .self_point_i, .last_point_i,
    .out_valid_i(out_valid_o), .out_ready_i, .center_lat_micro_i(center_lat_micro_o),
    .center_lon_micro_i(center_lon_micro_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_beat(input bit hp, input longint lat, input longint lon,
                           input bit self_m, input bit last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    has_point_i  <= hp;
    lat_micro_i  <= lat[LAT_W-1:0];
    lon_micro_i  <= lon[LON_W-1:0];
    self_point_i <= self_m;
    last_point_i <= last;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    n_sent++;
  endtask

  task automatic send_point_set(input int kind);
    int n;
    longint clat, clon, spread, lat, lon;
    bit self_m;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 8);
    clat = longint'($urandom_range(0, 160000000)) - 80000000;
    clon = (kind == 1) ? 179000000 : longint'($urandom_range(0, 360000000)) - 180000000;
    spread = (kind == 0) ? 90000000 : longint'($urandom_range(1000, 20000000));
    for (int i = 0; i < n; i++) begin
      if (kind == 3) begin
        lat = longint'(signed'(28'($urandom)));
        lon = longint'(signed'(29'($urandom)));
      end else begin
        lat = clat + longint'($urandom_range(0, 2 * spread)) - spread;
        lon = clon + longint'($urandom_range(0, 2 * spread)) - spread;
        if (lat > 90000000) lat = 90000000;
        if (lat < -90000000) lat = -90000000;
        if (lon > 180000000) lon -= 360000000;
        if (lon < -180000000) lon += 360000000;
      end
      self_m = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 15) == 0)
        send_beat(0, $urandom, $urandom, $urandom_range(0, 1), 0);
      send_beat(1, lat, lon, self_m, (i == n - 1) && ($urandom_range(0, 5) != 0));
    end
    if (!last_point_i)
      send_beat($urandom_range(0, 1), $urandom, $urandom, $urandom_range(0, 1), 1);
  endtask

  initial begin
    int guard;
    calm = 0;
    n_sent = 0;
    rst_ni = 0;
    in_valid_i = 0; has_point_i = 0; self_point_i = 0; last_point_i = 0;
    lat_micro_i = '0; lon_micro_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty set, extremes, clamp and wrap, dateline, self marks
    send_beat(0, 0, 0, 0, 1);
    send_beat(1, 90000000, 180000000, 0, 1);
    send_beat(1, -90000000, -180000000, 0, 1);
    send_beat(1, 134217727, 268435455, 0, 0);
    send_beat(1, -134217728, -268435456, 1, 1);
    send_beat(1, 10000000, 179000000, 0, 0);
    send_beat(1, -10000000, -179000000, 0, 1);
    send_beat(1, 45000000, 100000000, 0, 0);
    send_beat(1, 46000000, -100000000, 1, 0);
    send_beat(1, 47000000, 120000000, 1, 0);
    send_beat(0, 5, 5, 1, 1);
    send_beat(0, 1, 1, 1, 0);
    send_beat(1, 0, 0, 0, 0);
    send_beat(1, 0, 90000000, 0, 0);
    send_beat(1, 0, -90000001, 0, 1);
    send_beat(1, 1, -1, 0, 0);
    send_beat(1, -1, 1, 0, 1);

    while (n_sent < 1750) begin
      if ($urandom_range(0, 7) == 0) calm = ~calm;
      if ($urandom_range(0, 30) == 0) begin
        in_valid_i <= 1'b0;
        do @(negedge clk_i); while (pending != 0);
        @(posedge clk_i);
      end
      send_point_set($urandom_range(0, 3));
    end
    in_valid_i <= 1'b0;

    guard = 0;
    while (pending != 0 && guard < 100000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int stall;
    out_ready_i = 0;
    @(posedge rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(negedge clk_i); while (!out_valid_o);
      @(posedge clk_i);
    end
  end

endmodule

// ===== geo_map_center_bounds.f =====
+incdir+design
design/gmc_pkg.sv
design/gmc_front.sv
design/gmc_queue.sv
design/gmc_cordic.sv
design/gmc_back.sv
design/geo_map_center_bounds.sv
test/center_checker.sv
test/tb.sv
